// ===== rtl/grp_pkg.sv =====
package grp_pkg;

    localparam int COORD_W = 13;
    localparam int AREA_W  = 2 * COORD_W;
    localparam int ID_W    = 16;
    localparam int POS_W   = 12;

    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_CLEAR  = 3'd1;
    localparam logic [2:0] OP_SCLR   = 3'd2;
    localparam logic [2:0] OP_SEARCH = 3'd3;
    localparam logic [2:0] OP_DELETE = 3'd4;
    localparam logic [2:0] OP_INSERT = 3'd5;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } chunk_t;

    typedef struct packed {
        logic [2:0]         op;
        chunk_t             chunk;
        logic [AREA_W-1:0]  area;
        logic [COORD_W-1:0] rw;
        logic [COORD_W-1:0] rh;
    } cmd_t;

    typedef struct packed {
        chunk_t            chunk;
        logic [AREA_W-1:0] area;
        logic              valid;
        logic              rb;
        logic              f;
        chunk_t            carry;
    } link_t;

    typedef struct packed {
        logic               action;
        logic [ID_W-1:0]    request_id;
        logic [COORD_W-1:0] rect_width;
        logic [COORD_W-1:0] rect_height;
    } req_item_t;

    typedef struct packed {
        logic [ID_W-1:0]    echo_id;
        logic               placed;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [COORD_W-1:0] atlas_size;
        logic               list_overflow;
    } res_item_t;

endpackage

// ===== rtl/grp_chan_if.sv =====
interface grp_chan_if #(parameter type T_PAYLOAD = logic) ();
    logic     valid;
    logic     ready;
    T_PAYLOAD data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/grp_cell.sv =====
module grp_cell
    import grp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    input  logic  first,
    input  link_t up,
    input  link_t down,
    output link_t me
);

    chunk_t            chunk_reg;
    logic [AREA_W-1:0] area_reg;
    logic              valid_reg;
    logic              f_reg;
    chunk_t            carry_reg;
    logic              fit;
    logic              rb;

    assign fit = valid_reg && (chunk_reg.w >= cmd.rw) && (chunk_reg.h >= cmd.rh);
    assign rb  = !valid_reg || (cmd.area > area_reg)
              || ((cmd.area == area_reg) && (cmd.chunk.h > chunk_reg.h));

    assign me.chunk = chunk_reg;
    assign me.area  = area_reg;
    assign me.valid = valid_reg;
    assign me.rb    = rb;
    assign me.f     = f_reg;
    assign me.carry = carry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            f_reg     <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_CLEAR:
                begin
                    valid_reg <= first;
                    f_reg     <= 1'b0;
                end
                OP_SCLR:   f_reg <= 1'b0;
                OP_SEARCH: f_reg <= fit || up.f;
                OP_DELETE:
                begin
                    if (!up.f)
                        valid_reg <= up.valid;
                end
                OP_INSERT:
                begin
                    if (rb)
                        valid_reg <= down.rb ? down.valid : 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CLEAR:
            begin
                chunk_reg <= cmd.chunk;
                area_reg  <= cmd.area;
            end
            OP_SEARCH: carry_reg <= up.f ? up.carry : chunk_reg;
            OP_DELETE:
            begin
                if (!up.f)
                begin
                    chunk_reg <= up.chunk;
                    area_reg  <= up.area;
                end
            end
            OP_INSERT:
            begin
                if (rb)
                begin
                    chunk_reg <= down.rb ? down.chunk : cmd.chunk;
                    area_reg  <= down.rb ? down.area : cmd.area;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/guillotine_rect_packer_unit.sv =====
// channel  role    transaction
// req      sink    action, request_id, rect_width, rect_height
// res      source  echo_id, placed, pos_x, pos_y, atlas_size, list_overflow
//
// a placement searches and inserts the pieces, a new atlas clears; the search
// walks the row of cells one cell a cycle from the smallest end of the free list
// reset runs a clear step (S_INIT) before the first request is taken
// one request at a time; a finished result waits in the output register
module guillotine_rect_packer_unit
    import grp_pkg::*;
#(
    parameter int ATLAS_SIZE = 4096,
    parameter int FREE_SLOTS = 64
)
(
    input logic       clk,
    input logic       rst_n,
    grp_chan_if.sink   req,
    grp_chan_if.source res
);

    localparam int CNT_W = $clog2(FREE_SLOTS);
    localparam logic [COORD_W-1:0] FULL_SIDE = COORD_W'(ATLAS_SIZE);
    localparam logic [AREA_W-1:0]  FULL_AREA = AREA_W'(ATLAS_SIZE * ATLAS_SIZE);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCLR = 3'd2;
    localparam logic [2:0] S_SRCH = 3'd3;
    localparam logic [2:0] S_PICK = 3'd4;
    localparam logic [2:0] S_AREA = 3'd5;
    localparam logic [2:0] S_INS  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]         state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [1:0]         pidx_reg;
    logic [ID_W-1:0]    id_reg;
    logic [COORD_W-1:0] rw_reg;
    logic [COORD_W-1:0] rh_reg;
    chunk_t             chosen_reg;
    chunk_t             piece_reg;
    logic [AREA_W-1:0]  area_reg;
    logic               placed_reg;
    logic               lost_reg;
    logic [COORD_W-1:0] ex_reg;
    logic [COORD_W-1:0] ey_reg;
    logic               out_valid_reg;
    res_item_t          out_reg;

    cmd_t               cmd;
    chunk_t             piece;
    link_t              links [FREE_SLOTS];
    link_t              edge_link;
    logic [COORD_W-1:0] edge_x;
    logic [COORD_W-1:0] edge_y;
    logic               accept;

    function automatic logic [COORD_W-1:0] shrunk(input logic [COORD_W-1:0] ex,
                                                  input logic [COORD_W-1:0] ey);
        logic [COORD_W-1:0] m;
        logic [COORD_W-1:0] s;
        logic [COORD_W-1:0] cand;
        m = (ex > ey) ? ex : ey;
        s = FULL_SIDE;
        for (int b = 0; b < COORD_W; b++)
        begin
            cand = FULL_SIDE >> b;
            if ((cand != '0) && (cand >= m))
                s = cand;
        end
        return s;
    endfunction

    assign edge_link = '0;
    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

    genvar gi;
    generate
        for (gi = 0; gi < FREE_SLOTS; gi++)
        begin : g_cell
            grp_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd),
                .first (gi == 0),
                .up    ((gi == FREE_SLOTS - 1) ? edge_link : links[(gi + 1) % FREE_SLOTS]),
                .down  ((gi == 0) ? edge_link : links[(gi + FREE_SLOTS - 1) % FREE_SLOTS]),
                .me    (links[gi])
            );
        end
    endgenerate

    assign edge_x = links[0].carry.x + rw_reg;
    assign edge_y = links[0].carry.y + rh_reg;

    always_comb
    begin
        piece = chosen_reg;
        case (pidx_reg)
            2'd0:
            begin
                piece.y = chosen_reg.y + rh_reg;
                piece.w = rw_reg;
                piece.h = chosen_reg.h - rh_reg;
            end
            2'd1:
            begin
                piece.x = chosen_reg.x + rw_reg;
                piece.y = chosen_reg.y + rh_reg;
                piece.w = chosen_reg.w - rw_reg;
                piece.h = chosen_reg.h - rh_reg;
            end
            default:
            begin
                piece.x = chosen_reg.x + rw_reg;
                piece.w = chosen_reg.w - rw_reg;
                piece.h = rh_reg;
            end
        endcase
    end

    always_comb
    begin
        cmd.op    = OP_NOP;
        cmd.chunk = piece_reg;
        cmd.area  = area_reg;
        cmd.rw    = rw_reg;
        cmd.rh    = rh_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.op    = OP_CLEAR;
                cmd.chunk = '{x: '0, y: '0, w: FULL_SIDE, h: FULL_SIDE};
                cmd.area  = FULL_AREA;
            end
            S_IDLE:
            begin
                if (accept && req.data.action)
                begin
                    cmd.op    = OP_CLEAR;
                    cmd.chunk = '{x: '0, y: '0, w: FULL_SIDE, h: FULL_SIDE};
                    cmd.area  = FULL_AREA;
                end
            end
            S_SCLR: cmd.op = OP_SCLR;
            S_SRCH: cmd.op = OP_SEARCH;
            S_PICK:
            begin
                if (links[0].f)
                    cmd.op = OP_DELETE;
            end
            S_AREA: ;
            S_INS:
            begin
                if ((piece_reg.w != '0) && (piece_reg.h != '0))
                    cmd.op = OP_INSERT;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            pidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && res.ready && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_INIT: state_reg <= S_IDLE;
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= req.data.action ? S_DONE : S_SCLR;
                end
                S_SCLR:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_SRCH;
                end
                S_SRCH:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(FREE_SLOTS - 1))
                        state_reg <= S_PICK;
                end
                S_PICK:
                begin
                    pidx_reg  <= '0;
                    state_reg <= links[0].f ? S_AREA : S_DONE;
                end
                S_AREA: state_reg <= S_INS;
                S_INS:
                begin
                    pidx_reg  <= pidx_reg + 1'b1;
                    state_reg <= (pidx_reg == 2'd2) ? S_DONE : S_AREA;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || res.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_INIT;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_INIT:
            begin
                ex_reg <= '0;
                ey_reg <= '0;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    id_reg     <= req.data.request_id;
                    rw_reg     <= req.data.rect_width;
                    rh_reg     <= req.data.rect_height;
                    placed_reg <= 1'b0;
                    lost_reg   <= 1'b0;
                    chosen_reg <= '0;
                    if (req.data.action)
                    begin
                        ex_reg <= '0;
                        ey_reg <= '0;
                    end
                end
            end
            S_PICK:
            begin
                if (links[0].f)
                begin
                    chosen_reg <= links[0].carry;
                    placed_reg <= 1'b1;
                    if (edge_x > ex_reg)
                        ex_reg <= edge_x;
                    if (edge_y > ey_reg)
                        ey_reg <= edge_y;
                end
            end
            S_AREA:
            begin
                piece_reg <= piece;
                area_reg  <= piece.w * piece.h;
            end
            S_INS:
            begin
                if ((piece_reg.w != '0) && (piece_reg.h != '0) && links[FREE_SLOTS-1].valid)
                    lost_reg <= 1'b1;
            end
            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_reg.echo_id       <= id_reg;
                    out_reg.placed        <= placed_reg;
                    out_reg.pos_x         <= chosen_reg.x[POS_W-1:0];
                    out_reg.pos_y         <= chosen_reg.y[POS_W-1:0];
                    out_reg.atlas_size    <= shrunk(ex_reg, ey_reg);
                    out_reg.list_overflow <= lost_reg;
                end
            end
            default: ;
        endcase
    end

endmodule
